// ----- sv/ddmc_pkg.sv -----
`timescale 1ns / 1ps

package ddmc_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_LEFT_EDGE  = 2'd1,
    CMD_RIGHT_EDGE = 2'd2,
    CMD_SAMPLE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PULSE_MAX     = 2'd0,
    REG_PULSE_MIN     = 2'd1,
    REG_REVERSE_EDGES = 2'd2,
    REG_TURN_EDGES    = 2'd3
  } reg_idx_t;

  localparam logic [3:0] DRV_FWD = 4'd5;
  localparam logic [3:0] DRV_REV = 4'd10;
  localparam logic [3:0] DRV_ACW = 4'd9;
  localparam logic [3:0] DRV_CW  = 4'd6;

  localparam logic [15:0] PULSE_MAX_RESET     = 16'h3000;
  localparam logic [15:0] PULSE_MIN_RESET     = 16'h1000;
  localparam logic [7:0]  REVERSE_EDGES_RESET = 8'd200;
  localparam logic [7:0]  TURN_EDGES_RESET    = 8'd100;
  localparam logic [15:0] WIDTH_RESET         = 16'h2000;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] capture_time;
    logic [1:0]  bumpers;
    logic [1:0]  infrared;
  } req_t;

  typedef struct packed {
    logic [3:0]  motor_drive;
    logic [15:0] left_pulse_width;
    logic [15:0] right_pulse_width;
    logic        busy_res;
  } rsp_t;

  typedef struct packed {
    logic [15:0] pulse_max;
    logic [15:0] pulse_min;
    logic [7:0]  reverse_edges;
    logic [7:0]  turn_edges;
  } cfg_t;

endpackage

// ----- sv/ddmc_regs.sv -----
`timescale 1ns / 1ps

module ddmc_regs import ddmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_max     <= PULSE_MAX_RESET;
      cfg.pulse_min     <= PULSE_MIN_RESET;
      cfg.reverse_edges <= REVERSE_EDGES_RESET;
      cfg.turn_edges    <= TURN_EDGES_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_PULSE_MAX:     cfg.pulse_max     <= pwdata[15:0];
        REG_PULSE_MIN:     cfg.pulse_min     <= pwdata[15:0];
        REG_REVERSE_EDGES: cfg.reverse_edges <= pwdata[7:0];
        REG_TURN_EDGES:    cfg.turn_edges    <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PULSE_MAX:     prdata = {16'd0, cfg.pulse_max};
      REG_PULSE_MIN:     prdata = {16'd0, cfg.pulse_min};
      REG_REVERSE_EDGES: prdata = {24'd0, cfg.reverse_edges};
      REG_TURN_EDGES:    prdata = {24'd0, cfg.turn_edges};
    endcase
  end

endmodule

// ----- sv/ddmc_core.sv -----
`timescale 1ns / 1ps

module ddmc_core import ddmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  req_t item,
  input  cfg_t cfg,
  output rsp_t result
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_REVERSE = 2'd1,
    PH_TURN    = 2'd2
  } phase_t;

  logic [15:0] last_left, last_left_next;
  logic [15:0] last_right, last_right_next;
  logic [15:0] left_period, left_period_next;
  logic [15:0] right_period, right_period_next;
  logic [15:0] left_width, left_width_next;
  logic [15:0] right_width, right_width_next;
  logic [7:0]  edges_left, edges_left_next;
  phase_t      phase, phase_next;
  logic        turn_clockwise, turn_clockwise_next;

  phase_t      ph_pre;
  logic [7:0]  ed_pre;
  logic        left_grows;
  logic [15:0] diff, grow_w, shrink_w, grow_new, shrink_new;
  logic [16:0] sum;
  logic        busy;

  // wheel balance: widen the shorter-period side, narrow the other; past pulse_max they take pulse_max and pulse_min
  always_comb begin
    left_grows = right_period > left_period;
    diff       = left_grows ? (right_period - left_period) : (left_period - right_period);
    grow_w     = left_grows ? left_width : right_width;
    shrink_w   = left_grows ? right_width : left_width;
    sum        = {1'b0, grow_w} + {1'b0, diff};
    if (sum > {1'b0, cfg.pulse_max}) begin
      grow_new   = cfg.pulse_max;
      shrink_new = cfg.pulse_min;
    end else begin
      grow_new   = sum[15:0];
      shrink_new = (shrink_w > diff) ? (shrink_w - diff) : 16'd0;
    end
  end

  always_comb begin
    last_left_next      = last_left;
    last_right_next     = last_right;
    left_period_next    = left_period;
    right_period_next   = right_period;
    left_width_next     = left_width;
    right_width_next    = right_width;
    turn_clockwise_next = turn_clockwise;
    ph_pre              = phase;
    ed_pre              = edges_left;

    unique case (item.command)
      CMD_TICK: begin
        if (right_period != left_period) begin
          if (left_grows) begin
            left_width_next  = grow_new;
            right_width_next = shrink_new;
          end else begin
            right_width_next = grow_new;
            left_width_next  = shrink_new;
          end
        end
      end
      CMD_LEFT_EDGE: begin
        left_period_next = item.capture_time - last_left;
        last_left_next   = item.capture_time;
        if (edges_left != 8'd0) ed_pre = edges_left - 8'd1;
      end
      CMD_RIGHT_EDGE: begin
        right_period_next = item.capture_time - last_right;
        last_right_next   = item.capture_time;
        if (edges_left != 8'd0) ed_pre = edges_left - 8'd1;
      end
      CMD_SAMPLE: begin
        if (phase != PH_REVERSE && phase != PH_TURN) begin
          ph_pre = PH_IDLE;
          if (item.bumpers != 2'b00) begin
            turn_clockwise_next = !item.bumpers[1];
            ph_pre              = PH_REVERSE;
            ed_pre              = cfg.reverse_edges;
          end else if (item.infrared == 2'b01 || item.infrared == 2'b10) begin
            turn_clockwise_next = item.infrared[1];
            ph_pre              = PH_TURN;
            ed_pre              = cfg.turn_edges;
          end
        end
      end
    endcase

    // phases whose edge count has run out advance at once
    phase_next      = ph_pre;
    edges_left_next = ed_pre;
    if (phase_next == PH_REVERSE && edges_left_next == 8'd0) begin
      phase_next      = PH_TURN;
      edges_left_next = cfg.turn_edges;
    end
    if (phase_next == PH_TURN && edges_left_next == 8'd0) begin
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    busy = (phase_next == PH_REVERSE) || (phase_next == PH_TURN);
    priority if (phase_next == PH_REVERSE) begin
      result.motor_drive = DRV_REV;
    end else if (phase_next == PH_TURN) begin
      result.motor_drive = turn_clockwise_next ? DRV_CW : DRV_ACW;
    end else begin
      result.motor_drive = DRV_FWD;
    end
    result.left_pulse_width  = left_width_next;
    result.right_pulse_width = right_width_next;
    result.busy_res          = busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left      <= 16'd0;
      last_right     <= 16'd0;
      left_period    <= 16'd0;
      right_period   <= 16'd0;
      left_width     <= WIDTH_RESET;
      right_width    <= WIDTH_RESET;
      edges_left     <= 8'd0;
      phase          <= PH_IDLE;
      turn_clockwise <= 1'b0;
    end else if (en) begin
      last_left      <= last_left_next;
      last_right     <= last_right_next;
      left_period    <= left_period_next;
      right_period   <= right_period_next;
      left_width     <= left_width_next;
      right_width    <= right_width_next;
      edges_left     <= edges_left_next;
      phase          <= phase_next;
      turn_clockwise <= turn_clockwise_next;
    end
  end

endmodule

// ----- sv/differential_drive_motion_controller.sv -----
`timescale 1ns / 1ps
// a request is registered in the input stage on acceptance, and its response is registered
// in rsp when the stage advances, which waits while an unaccepted response is held
// throughput: one request per cycle while rsp_ready holds; the state update is one registered pass
// set by the input stage and the single core pass that reads the stored state
// reset: synchronous active-high rst empties both stages, idles the drive,
// sets both pulse widths to 8192 and loads the register defaults

module differential_drive_motion_controller import ddmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp
);

  cfg_t cfg;
  req_t stage;
  logic stage_vld;
  logic advance;
  rsp_t result;

  ddmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddmc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (stage),
    .cfg    (cfg),
    .result (result)
  );

  assign advance   = stage_vld && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) stage_vld <= req_valid;
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) stage <= req;
    if (advance) rsp <= result;
  end

`ifndef SYNTH
  a_busy_matches_drive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.busy_res == (rsp.motor_drive != DRV_FWD)))
    else $error("busy flag disagrees with motor drive");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_vld && !advance) |=> (stage_vld && $stable(stage)))
    else $error("stalled request lost from input stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> stage_vld)
    else $error("accepted request not held in input stage");

  a_advance_shows_rsp: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("processed request gave no response");
`endif

endmodule

// ----- tb/tb_differential_drive_motion_controller.sv -----
`timescale 1ns / 1ps

module tb_differential_drive_motion_controller;
  import ddmc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_REVERSE = 2'd1,
    PH_TURN    = 2'd2
  } phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;

  // predicted controller state
  cfg_t        drive_cfg;
  logic [15:0] last_left_cap, last_right_cap;
  logic [15:0] left_period, right_period;
  logic [15:0] left_width, right_width;
  logic [7:0]  edges_left;
  phase_t      phase;
  logic        turn_cw;

  rsp_t expected_drive_q[$];
  logic [15:0] timer_now = '0;
  bit   traffic_gaps = 1'b1;
  bit   rsp_stalls = 1'b1;
  int   error_count = 0;
  int   requests_accepted = 0;
  int   responses_checked = 0;
  int   settings_applied = 0;
  int   manoeuvres_started = 0;

  differential_drive_motion_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  function automatic void reset_drive_model();
    drive_cfg.pulse_max     = PULSE_MAX_RESET;
    drive_cfg.pulse_min     = PULSE_MIN_RESET;
    drive_cfg.reverse_edges = REVERSE_EDGES_RESET;
    drive_cfg.turn_edges    = TURN_EDGES_RESET;
    last_left_cap  = '0;
    last_right_cap = '0;
    left_period    = '0;
    right_period   = '0;
    left_width     = WIDTH_RESET;
    right_width    = WIDTH_RESET;
    edges_left     = '0;
    phase          = PH_IDLE;
    turn_cw        = 1'b0;
  endfunction

  function automatic void settle_phase();
    if (phase == PH_REVERSE && edges_left == 0) begin
      phase = PH_TURN;
      edges_left = drive_cfg.turn_edges;
    end
    if (phase == PH_TURN && edges_left == 0) phase = PH_IDLE;
  endfunction

  function automatic void count_wheel_edge();
    if (edges_left != 0) edges_left = edges_left - 8'd1;
    settle_phase();
  endfunction

  function automatic void take_sensor_sample(logic [1:0] bumpers, logic [1:0] infrared);
    if (phase == PH_REVERSE || phase == PH_TURN) return;
    phase = PH_IDLE;
    if (bumpers != 2'b00) begin
      // left bumper wins and turns anticlockwise
      turn_cw = !bumpers[1];
      phase = PH_REVERSE;
      edges_left = drive_cfg.reverse_edges;
      manoeuvres_started++;
      settle_phase();
    end else if (infrared == 2'b01 || infrared == 2'b10) begin
      turn_cw = (infrared == 2'b10);
      phase = PH_TURN;
      edges_left = drive_cfg.turn_edges;
      manoeuvres_started++;
      settle_phase();
    end
  endfunction

  function automatic rsp_t predict_drive(req_t r);
    rsp_t        res;
    logic [16:0] sum;
    logic [15:0] corr, grow, shrink;
    logic        right_grows;
    case (r.command)
      CMD_TICK: begin
        if (left_period != right_period) begin
          right_grows = left_period > right_period;
          corr   = right_grows ? left_period - right_period : right_period - left_period;
          grow   = right_grows ? right_width : left_width;
          shrink = right_grows ? left_width : right_width;
          sum    = {1'b0, grow} + {1'b0, corr};
          if (sum > {1'b0, drive_cfg.pulse_max}) begin
            grow   = drive_cfg.pulse_max;
            shrink = drive_cfg.pulse_min;
          end else begin
            grow   = sum[15:0];
            shrink = (shrink > corr) ? shrink - corr : 16'd0;
          end
          if (right_grows) begin
            right_width = grow;
            left_width  = shrink;
          end else begin
            left_width  = grow;
            right_width = shrink;
          end
        end
      end
      CMD_LEFT_EDGE: begin
        left_period   = r.capture_time - last_left_cap;
        last_left_cap = r.capture_time;
        count_wheel_edge();
      end
      CMD_RIGHT_EDGE: begin
        right_period   = r.capture_time - last_right_cap;
        last_right_cap = r.capture_time;
        count_wheel_edge();
      end
      default: take_sensor_sample(r.bumpers, r.infrared);
    endcase
    case (phase)
      PH_REVERSE: res.motor_drive = DRV_REV;
      PH_TURN:    res.motor_drive = turn_cw ? DRV_CW : DRV_ACW;
      default:    res.motor_drive = DRV_FWD;
    endcase
    res.left_pulse_width  = left_width;
    res.right_pulse_width = right_width;
    res.busy_res          = (phase == PH_REVERSE || phase == PH_TURN);
    return res;
  endfunction

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      expected_drive_q.push_back(predict_drive(req));
      requests_accepted++;
    end
  end

  function automatic void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      if (error_count < 50)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_drive_q.size() == 0) begin
        error_count++;
        if (error_count < 50)
          $display("%0t: unexpected response, expected none actual %h", $time, rsp);
      end else begin
        exp_rsp = expected_drive_q.pop_front();
        compare_field("motor_drive", {12'd0, exp_rsp.motor_drive}, {12'd0, rsp.motor_drive});
        compare_field("left_pulse_width", exp_rsp.left_pulse_width, rsp.left_pulse_width);
        compare_field("right_pulse_width", exp_rsp.right_pulse_width, rsp.right_pulse_width);
        compare_field("busy_res", {15'd0, exp_rsp.busy_res}, {15'd0, rsp.busy_res});
        responses_checked++;
      end
    end
  end

  // response side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (rsp_stalls && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic req_t make_req(cmd_t cmd, logic [15:0] cap, logic [1:0] bumpers,
                                    logic [1:0] infrared);
    req_t r;
    r.command      = cmd;
    r.capture_time = cap;
    r.bumpers      = bumpers;
    r.infrared     = infrared;
    return r;
  endfunction

  task automatic send_request(req_t r);
    if (traffic_gaps && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PULSE_MAX:     drive_cfg.pulse_max = value;
      REG_PULSE_MIN:     drive_cfg.pulse_min = value;
      REG_REVERSE_EDGES: drive_cfg.reverse_edges = value[7:0];
      default:           drive_cfg.turn_edges = value[7:0];
    endcase
  endtask

  task automatic apply_settings(logic [15:0] pmax, logic [15:0] pmin, logic [7:0] rev,
                                logic [7:0] turn);
    wait_drained();
    write_register(REG_PULSE_MAX, pmax);
    write_register(REG_PULSE_MIN, pmin);
    write_register(REG_REVERSE_EDGES, {8'd0, rev});
    write_register(REG_TURN_EDGES, {8'd0, turn});
    settings_applied++;
  endtask

  task automatic test_reset_state();
    send_request(make_req(CMD_TICK, 16'h0000, 2'b00, 2'b00));
    send_request(make_req(CMD_SAMPLE, 16'hFFFF, 2'b00, 2'b00));
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b00, 2'b11));
  endtask

  task automatic test_period_balance();
    send_request(make_req(CMD_LEFT_EDGE, 16'h0100, 2'b00, 2'b00));
    send_request(make_req(CMD_RIGHT_EDGE, 16'h0040, 2'b00, 2'b00));
    send_request(make_req(CMD_TICK, 16'h0000, 2'b00, 2'b00));
    // timer wrap gives a long left period, so the tick clamps
    send_request(make_req(CMD_LEFT_EDGE, 16'h0010, 2'b00, 2'b00));
    send_request(make_req(CMD_TICK, 16'h0000, 2'b00, 2'b00));
    send_request(make_req(CMD_RIGHT_EDGE, 16'hFFFF, 2'b00, 2'b00));
    send_request(make_req(CMD_TICK, 16'hFFFF, 2'b11, 2'b11));
    send_request(make_req(CMD_RIGHT_EDGE, 16'h0000, 2'b00, 2'b00));
  endtask

  task automatic test_sensor_manoeuvres();
    apply_settings(PULSE_MAX_RESET, PULSE_MIN_RESET, 8'd1, 8'd2);
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b11, 2'b01));
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b00, 2'b01));
    send_request(make_req(CMD_LEFT_EDGE, 16'h1000, 2'b00, 2'b00));
    send_request(make_req(CMD_RIGHT_EDGE, 16'h1200, 2'b00, 2'b00));
    send_request(make_req(CMD_LEFT_EDGE, 16'h2000, 2'b00, 2'b00));
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b00, 2'b10));
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b01, 2'b00));
    send_request(make_req(CMD_RIGHT_EDGE, 16'h2100, 2'b00, 2'b00));
    send_request(make_req(CMD_RIGHT_EDGE, 16'h2300, 2'b00, 2'b00));
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b01, 2'b10));
    // zero edge counts finish the manoeuvre in the same request
    apply_settings(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b10, 2'b00));
    send_request(make_req(CMD_SAMPLE, 16'h0000, 2'b00, 2'b01));
    send_request(make_req(CMD_TICK, 16'h0000, 2'b00, 2'b00));
  endtask

  task automatic run_random_requests(int count);
    req_t r;
    int   sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      r.capture_time = 16'($urandom);
      r.bumpers      = 2'($urandom);
      r.infrared     = 2'($urandom);
      if (sel < 3) begin
        r.command = CMD_TICK;
      end else if (sel < 9) begin
        r.command = (sel < 6) ? CMD_LEFT_EDGE : CMD_RIGHT_EDGE;
        if ($urandom_range(0, 7) != 0) begin
          timer_now = timer_now + 16'($urandom_range(1, 3000));
          r.capture_time = timer_now;
        end
      end else begin
        r.command = CMD_SAMPLE;
      end
      send_request(r);
      if (traffic_gaps && $urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  task automatic test_random_settings();
    apply_settings(PULSE_MAX_RESET, PULSE_MIN_RESET, REVERSE_EDGES_RESET, TURN_EDGES_RESET);
    run_random_requests(300);
    apply_settings(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    run_random_requests(300);
    apply_settings(16'h0000, 16'hFFFF, 8'hFF, 8'hFF);
    run_random_requests(300);
    apply_settings(16'($urandom), 16'($urandom), 8'($urandom_range(0, 15)),
                   8'($urandom_range(0, 15)));
    run_random_requests(300);
    apply_settings(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    run_random_requests(300);
  endtask

  task automatic test_quiet_stream();
    traffic_gaps = 1'b0;
    rsp_stalls   = 1'b0;
    apply_settings(16'hFFFF, 16'hFFFF, 8'd3, 8'd5);
    run_random_requests(300);
  endtask

  initial begin
    reset_drive_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_period_balance();
    test_sensor_manoeuvres();
    test_random_settings();
    test_quiet_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_drive_q.size() != 0) begin
      error_count++;
      $display("%0t: responses missing, expected %0d actual 0", $time, expected_drive_q.size());
    end
    $display("covered %0d requests and %0d checked responses over %0d register settings,",
             requests_accepted, responses_checked, settings_applied);
    $display("with %0d manoeuvres started and random stalls on both sides", manoeuvres_started);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ddmc_pkg.sv
sv/ddmc_regs.sv
sv/ddmc_core.sv
sv/differential_drive_motion_controller.sv
tb/tb_differential_drive_motion_controller.sv
